// ===== sv/msq_pkg.sv =====
// Shared types and constants for the MIDI step sequencer.
package msq_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_PRESS = 2'd1,
    MODE_MIDI  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    RS_STOPPED = 2'd0,
    RS_RUNNING = 2'd1,
    RS_ARMED   = 2'd2
  } run_state_t;

  // What the result stage has to build for one item.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_STEP,
    OP_STOP,
    OP_FWD
  } op_t;

  localparam logic [7:0] MSG_NOTE_ON     = 8'h90;
  localparam logic [7:0] MSG_NOTE_OFF    = 8'h80;
  localparam logic [7:0] STATUS_HI_MASK  = 8'hf0;
  localparam logic [6:0] VELOCITY_RESET  = 7'd127;
  localparam logic [6:0] REST_NOTE       = 7'd0;
  localparam int         NUM_INIT_NOTES  = 4;
  localparam logic [6:0] INIT_NOTES [NUM_INIT_NOTES] = '{7'd69, 7'd71, 7'd73, 7'd76};
  localparam int         LEN_RESET       = 4;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] status_in;
    logic [6:0] data1_in;
    logic [6:0] data2_in;
  } in_t;

  typedef struct packed {
    logic [7:0] status_out;
    logic [6:0] data1_out;
    logic [6:0] data2_out;
    logic       last;
    logic [1:0] run_state;
  } out_t;

  // Item handed from the store stage to the result stage.
  typedef struct packed {
    op_t        op;
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
    logic [6:0] note;
    logic [1:0] run_state;
  } s1_t;

endpackage

// ===== sv/msq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/msq_front.sv =====
// Store stage: run state, position, length, note store access and the item register.
module msq_front #(
  parameter int SEQ_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  msq_pkg::in_t  in_data,
  output logic          s1_valid,
  input  logic          s1_ready,
  output msq_pkg::s1_t  s1
);

  localparam int AW   = $clog2(SEQ_DEPTH);
  localparam int LMAX = (SEQ_DEPTH > msq_pkg::LEN_RESET) ? SEQ_DEPTH : msq_pkg::LEN_RESET;
  localparam int PW   = $clog2(LMAX + 1);
  localparam logic [PW-1:0] DEPTH_P   = PW'(SEQ_DEPTH);
  localparam logic [PW-1:0] LEN_RST_P = PW'(msq_pkg::LEN_RESET);

  msq_pkg::run_state_t run_r, run_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [PW-1:0]       len_r, len_nxt;
  logic [SEQ_DEPTH-1:0] vld_r;
  logic                s1_valid_r;
  msq_pkg::s1_t        s1_r, s1_nxt;
  logic                use_ram_r;
  logic [6:0]          dflt_note_r;

  logic          accept;
  logic [PW:0]   pos_inc;
  logic [PW-1:0] step_pos;
  logic          rd_en, wr_en;
  logic [PW-1:0] rd_pos;
  logic [6:0]    wr_note;
  logic          rd_oob;
  logic [6:0]    init_note;
  logic [6:0]    dflt_note;
  logic          use_ram;
  logic [6:0]    ram_rdata;

  assign in_ready = !s1_valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  assign pos_inc  = {1'b0, pos_r} + (PW + 1)'(1);
  assign step_pos = (pos_inc >= {1'b0, len_r}) ? '0 : pos_inc[PW-1:0];

  always_comb begin
    run_nxt = run_r;
    pos_nxt = pos_r;
    len_nxt = len_r;
    rd_en   = 1'b0;
    rd_pos  = '0;
    wr_en   = 1'b0;
    wr_note = msq_pkg::REST_NOTE;
    s1_nxt           = '0;
    s1_nxt.op        = msq_pkg::OP_NONE;
    s1_nxt.status    = in_data.status_in;
    s1_nxt.data1     = in_data.data1_in;
    s1_nxt.data2     = in_data.data2_in;
    case (in_data.mode)
      msq_pkg::MODE_TICK: begin
        case (run_r)
          msq_pkg::RS_STOPPED: begin
            wr_en   = 1'b1;
            wr_note = msq_pkg::REST_NOTE;
          end
          msq_pkg::RS_ARMED: begin
            pos_nxt   = '0;
            rd_en     = 1'b1;
            rd_pos    = '0;
            run_nxt   = msq_pkg::RS_RUNNING;
            s1_nxt.op = msq_pkg::OP_START;
          end
          default: begin
            pos_nxt   = step_pos;
            rd_en     = 1'b1;
            rd_pos    = step_pos;
            s1_nxt.op = msq_pkg::OP_STEP;
          end
        endcase
      end
      msq_pkg::MODE_PRESS: begin
        case (run_r)
          msq_pkg::RS_STOPPED: run_nxt = msq_pkg::RS_ARMED;
          msq_pkg::RS_ARMED:   run_nxt = msq_pkg::RS_STOPPED;
          default: begin
            run_nxt   = msq_pkg::RS_STOPPED;
            pos_nxt   = '0;
            s1_nxt.op = msq_pkg::OP_STOP;
          end
        endcase
      end
      msq_pkg::MODE_MIDI: begin
        if (run_r == msq_pkg::RS_STOPPED) begin
          if ((in_data.status_in & msq_pkg::STATUS_HI_MASK) == msq_pkg::MSG_NOTE_ON) begin
            wr_en   = 1'b1;
            wr_note = in_data.data1_in;
          end
        end else begin
          s1_nxt.op = msq_pkg::OP_FWD;
        end
      end
      default: ;
    endcase
    // Drop recording once the store is full.
    if (wr_en) begin
      if (pos_r < DEPTH_P) begin
        pos_nxt = pos_inc[PW-1:0];
        len_nxt = pos_inc[PW-1:0];
      end else begin
        wr_en = 1'b0;
      end
    end
    s1_nxt.run_state = run_nxt;
  end

  // Entries never written read as their reset contents; steps past the store are rests.
  assign rd_oob = rd_pos >= DEPTH_P;

  always_comb begin
    init_note = msq_pkg::REST_NOTE;
    for (int i = 0; i < msq_pkg::NUM_INIT_NOTES; i++) begin
      if (rd_pos == PW'(i)) begin
        init_note = msq_pkg::INIT_NOTES[i];
      end
    end
  end

  assign dflt_note = rd_oob ? msq_pkg::REST_NOTE : init_note;
  assign use_ram   = !rd_oob && vld_r[rd_pos[AW-1:0]];

  msq_ram #(
    .WIDTH (7),
    .DEPTH (SEQ_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && wr_en),
    .waddr (pos_r[AW-1:0]),
    .wdata (wr_note),
    .re    (accept && rd_en),
    .raddr (rd_pos[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= msq_pkg::RS_RUNNING;
      pos_r      <= '0;
      len_r      <= LEN_RST_P;
      vld_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        run_r <= run_nxt;
        pos_r <= pos_nxt;
        len_r <= len_nxt;
        if (wr_en) begin
          vld_r[pos_r[AW-1:0]] <= 1'b1;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Hold the item while the result stage stalls; the RAM read data holds as well.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r        <= s1_nxt;
      dflt_note_r <= dflt_note;
      use_ram_r   <= use_ram;
    end
  end

  always_comb begin
    s1      = s1_r;
    s1.note = use_ram_r ? ram_rdata : dflt_note_r;
  end

  assign s1_valid = s1_valid_r;

endmodule

// ===== sv/msq_back.sv =====
// Result stage: builds note-on/note-off/forwarded messages and buffers them for output.
module msq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_data,
  input  logic          s1_valid,
  output logic          s1_ready,
  input  msq_pkg::s1_t  s1,
  output logic          out_valid,
  input  logic          out_ready,
  output msq_pkg::out_t out_data
);

  logic [6:0]    velocity_r;
  logic [6:0]    cur_note_r;
  msq_pkg::out_t ob0_r, ob1_r;
  logic [1:0]    ob_cnt_r;

  msq_pkg::out_t msg_off, msg_on, msg_fwd, m0, m1;
  logic          has_off, has_on;
  logic [1:0]    n;
  logic          ob_free, load, out_beat, s1_fire;

  always_comb begin
    msg_off            = '0;
    msg_off.status_out = msq_pkg::MSG_NOTE_OFF;
    msg_off.data1_out  = cur_note_r;
    msg_off.data2_out  = velocity_r;
    msg_off.run_state  = s1.run_state;
    msg_on             = msg_off;
    msg_on.status_out  = msq_pkg::MSG_NOTE_ON;
    msg_on.data1_out   = s1.note;
    msg_fwd            = '0;
    msg_fwd.status_out = s1.status;
    msg_fwd.data1_out  = s1.data1;
    msg_fwd.data2_out  = s1.data2;
    msg_fwd.run_state  = s1.run_state;

    has_off = 1'b0;
    has_on  = 1'b0;
    case (s1.op)
      msq_pkg::OP_START: has_on = s1.note != msq_pkg::REST_NOTE;
      msq_pkg::OP_STEP: begin
        has_off = cur_note_r != msq_pkg::REST_NOTE;
        has_on  = s1.note != msq_pkg::REST_NOTE;
      end
      msq_pkg::OP_STOP: has_off = cur_note_r != msq_pkg::REST_NOTE;
      default: ;
    endcase

    m1 = msg_on;
    if (s1.op == msq_pkg::OP_FWD) begin
      m0 = msg_fwd;
      n  = 2'd1;
    end else if (has_off) begin
      m0 = msg_off;
      n  = has_on ? 2'd2 : 2'd1;
    end else begin
      m0 = msg_on;
      n  = has_on ? 2'd1 : 2'd0;
    end
    m0.last = (n == 2'd1);
    m1.last = 1'b1;
  end

  assign out_valid = ob_cnt_r != 2'd0;
  assign out_data  = ob0_r;
  assign out_beat  = out_valid && out_ready;
  assign ob_free   = (ob_cnt_r == 2'd0) || ((ob_cnt_r == 2'd1) && out_ready);
  assign s1_ready  = (n == 2'd0) || ob_free;
  assign s1_fire   = s1_valid && s1_ready;
  assign load      = s1_fire && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      velocity_r <= msq_pkg::VELOCITY_RESET;
      cur_note_r <= msq_pkg::INIT_NOTES[0];
      ob_cnt_r   <= 2'd0;
    end else begin
      if (cfg_we) begin
        velocity_r <= cfg_data;
      end
      // Track the note now sounding at the current step.
      if (s1_fire && (s1.op == msq_pkg::OP_START || s1.op == msq_pkg::OP_STEP)) begin
        cur_note_r <= s1.note;
      end
      if (load) begin
        ob_cnt_r <= n;
      end else if (out_beat) begin
        ob_cnt_r <= ob_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob0_r <= m0;
      ob1_r <= m1;
    end else if (out_beat) begin
      ob0_r <= ob1_r;
    end
  end

endmodule

// ===== sv/midi_step_sequencer_unit.sv =====
// Top level of the MIDI step sequencer: store stage, result stage and checks.
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_ready  | one item: tick, press or MIDI msg
//  out_    | output    | out_valid/out_ready| one MIDI message, last marks end
//  cfg_    | input     | cfg_we only        | out_velocity, 7 bits
//
// An item passes the store stage (note store read or write, one RAM port
// each) and then the result stage; its first message is registered in the
// item register and then the output buffer. A new item is taken every cycle
// while output keeps up; an item with two messages holds the output register
// for two beats, so the output buffer limits the sustained item rate.
// Reset is synchronous and needs no clearing pass: per-entry valid bits give
// the note store its reset contents. A stall on out_ready backs up into in_ready.
module midi_step_sequencer_unit #(
  parameter int SEQ_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  msq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output msq_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_data
);

  logic         s1_valid;
  logic         s1_ready;
  msq_pkg::s1_t s1;

  msq_front #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  msq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1        (s1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Input stalls only behind an item waiting in the result stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid)
    else $error("input stalled with result stage empty");

  // A stalled item keeps its contents, including the held RAM read data.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1))
    else $error("stalled item changed");

  // A message that is not the last of its item is followed by another.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> out_valid)
    else $error("item messages cut short");

  // Generated note messages only come from ticks and presses, never while stopped
  // except the final note-off of a stop press.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_state == msq_pkg::RS_STOPPED
      |-> out_data.status_out == msq_pkg::MSG_NOTE_OFF && out_data.last)
    else $error("message while stopped other than the stop note-off");

endmodule

// ===== test/sequencer_checker.sv =====
`timescale 1ns / 100ps
// Checker for the step sequencer: tracks note store and play state, checks every out beat.
module sequencer_checker
  import msq_pkg::*;
#(
  parameter int SEQ_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_t        in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_t       out_data,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  output int         pending,
  output int         fail_count
);

  logic [6:0]  velocity;
  run_state_t  play_state;
  logic [6:0]  notes [SEQ_DEPTH];
  int unsigned step_pos;
  int unsigned seq_len;
  out_t        expected_msgs [$];

  function automatic logic [6:0] note_at(int unsigned idx);
    if (idx >= SEQ_DEPTH) return REST_NOTE;
    return notes[idx];
  endfunction

  function automatic out_t gen_msg(logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    out_t m;
    m = '0;
    m.status_out = st;
    m.data1_out = d1;
    m.data2_out = d2;
    return m;
  endfunction

  task automatic record_note(logic [6:0] nt);
    // drop the note once the store is full
    if (step_pos < SEQ_DEPTH) begin
      notes[step_pos] = nt;
      step_pos++;
      seq_len = step_pos;
    end
  endtask

  task automatic play_item(in_t it);
    out_t       msgs [2];
    int         n;
    logic [6:0] nt;
    n = 0;
    case (it.mode)
      MODE_TICK: begin
        case (play_state)
          RS_STOPPED: record_note(REST_NOTE);
          RS_ARMED: begin
            step_pos = 0;
            nt = note_at(0);
            if (nt != REST_NOTE) begin
              msgs[n] = gen_msg(MSG_NOTE_ON, nt, velocity);
              n++;
            end
            play_state = RS_RUNNING;
          end
          default: begin
            nt = note_at(step_pos);
            if (nt != REST_NOTE) begin
              msgs[n] = gen_msg(MSG_NOTE_OFF, nt, velocity);
              n++;
            end
            step_pos++;
            if (step_pos >= seq_len) step_pos = 0;
            nt = note_at(step_pos);
            if (nt != REST_NOTE) begin
              msgs[n] = gen_msg(MSG_NOTE_ON, nt, velocity);
              n++;
            end
          end
        endcase
      end
      MODE_PRESS: begin
        case (play_state)
          RS_STOPPED: play_state = RS_ARMED;
          RS_ARMED:   play_state = RS_STOPPED;
          default: begin
            nt = note_at(step_pos);
            if (nt != REST_NOTE) begin
              msgs[n] = gen_msg(MSG_NOTE_OFF, nt, velocity);
              n++;
            end
            play_state = RS_STOPPED;
            step_pos = 0;
          end
        endcase
      end
      MODE_MIDI: begin
        if (play_state == RS_STOPPED) begin
          if ((it.status_in & STATUS_HI_MASK) == MSG_NOTE_ON) record_note(it.data1_in);
        end else begin
          msgs[n] = gen_msg(it.status_in, it.data1_in, it.data2_in);
          n++;
        end
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      msgs[k].run_state = play_state;
      msgs[k].last = (k == n - 1);
      expected_msgs.push_back(msgs[k]);
    end
  endtask

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (!rst_n) begin
      velocity = VELOCITY_RESET;
      play_state = RS_RUNNING;
      for (int i = 0; i < SEQ_DEPTH; i++) notes[i] = REST_NOTE;
      for (int i = 0; i < NUM_INIT_NOTES; i++) notes[i] = INIT_NOTES[i];
      step_pos = 0;
      seq_len = LEN_RESET;
      expected_msgs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_msgs.size() == 0) begin
          report("beat with nothing expected, status", out_data.status_out, 8'h00);
        end else begin
          want = expected_msgs.pop_front();
          if (out_data.status_out !== want.status_out)
            report("status_out", out_data.status_out, want.status_out);
          if (out_data.data1_out !== want.data1_out)
            report("data1_out", 8'(out_data.data1_out), 8'(want.data1_out));
          if (out_data.data2_out !== want.data2_out)
            report("data2_out", 8'(out_data.data2_out), 8'(want.data2_out));
          if (out_data.last !== want.last)
            report("last", 8'(out_data.last), 8'(want.last));
          if (out_data.run_state !== want.run_state)
            report("run_state", 8'(out_data.run_state), 8'(want.run_state));
        end
      end
      if (cfg_we) velocity = cfg_data;
      if (in_valid && in_ready) play_item(in_data);
    end
    pending = expected_msgs.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top for the step sequencer: clock, reset, stimulus and verdict.
module testbench;
  import msq_pkg::*;

  localparam int         SEQ_DEPTH    = 64;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         STALL_CYCLES = 200;
  localparam int         RANDOM_ITEMS = 1100;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_t        in_data;
  logic       out_valid;
  logic       out_ready;
  out_t       out_data;
  logic       cfg_we;
  logic [6:0] cfg_data;
  int         pending;
  int         fail_count;
  int         snd_idle;
  int         rcv_idle;
  int         hold_starts = 0;
  int         items_sent;
  run_state_t cur_rs;

  midi_step_sequencer_unit #(.SEQ_DEPTH(SEQ_DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  sequencer_checker #(.SEQ_DEPTH(SEQ_DEPTH)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_starts != hold_seen) begin
        hold_seen = hold_starts;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  initial begin : watchdog
    #(5_000_000);
    $display("testbench: FAIL");
    $finish;
  end

  function automatic in_t mk_item(logic [1:0] mode, logic [7:0] st, logic [6:0] d1,
                                  logic [6:0] d2);
    in_t it;
    it.mode = mode;
    it.status_in = st;
    it.data1_in = d1;
    it.data2_in = d2;
    return it;
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [6:0] rnd_data();
    return 7'($urandom_range(127));
  endfunction

  task automatic send(in_t item);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.mode != MODE_UNUSED) items_sent++;
    case (item.mode)
      MODE_TICK:  if (cur_rs == RS_ARMED) cur_rs = RS_RUNNING;
      MODE_PRESS: cur_rs = (cur_rs == RS_STOPPED) ? RS_ARMED : RS_STOPPED;
      default: ;
    endcase
  endtask

  // Hold valid low until every expected beat is back and the pipe has emptied.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_velocity(logic [6:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic tick();
    send(mk_item(MODE_TICK, rnd_byte(), rnd_data(), rnd_data()));
  endtask

  task automatic press();
    send(mk_item(MODE_PRESS, rnd_byte(), rnd_data(), rnd_data()));
  endtask

  task automatic note_on(logic [6:0] nt);
    send(mk_item(MODE_MIDI, MSG_NOTE_ON | 8'($urandom_range(15)), nt, rnd_data()));
  endtask

  task automatic midi_rand();
    send(mk_item(MODE_MIDI, rnd_byte(), rnd_data(), rnd_data()));
  endtask

  task automatic midi_other();
    logic [7:0] st;
    st = rnd_byte();
    if ((st & STATUS_HI_MASK) == MSG_NOTE_ON) st = MSG_NOTE_OFF | (st & ~STATUS_HI_MASK);
    send(mk_item(MODE_MIDI, st, rnd_data(), rnd_data()));
  endtask

  task automatic ensure_stopped();
    while (cur_rs != RS_STOPPED) press();
  endtask

  task automatic record_burst(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(9);
      if (r < 6) note_on(rnd_data());
      else if (r < 8) tick();
      else if (r == 8) midi_other();
      else note_on(REST_NOTE);
    end
  endtask

  // Record a pattern, arm, start and play it for a while.
  task automatic well_formed(bit long_rec);
    int m;
    ensure_stopped();
    if (long_rec || $urandom_range(11) == 0) record_burst($urandom_range(60, 70));
    else record_burst($urandom_range(1, 8));
    press();
    if ($urandom_range(3) == 0) begin
      // drop back to stopped and keep recording where we left off
      press();
      record_burst($urandom_range(1, 3));
      press();
    end
    if ($urandom_range(2) == 0) midi_rand();
    tick();
    m = $urandom_range(2, 20);
    repeat (m) begin
      if ($urandom_range(4) == 0) midi_rand();
      else tick();
    end
    if ($urandom_range(3) != 0) press();
  endtask

  task automatic noise();
    repeat ($urandom_range(1, 10))
      send(mk_item(2'($urandom_range(3)), rnd_byte(), rnd_data(), rnd_data()));
  endtask

  // Stall the receiver while items keep coming so the block backs up into in_ready.
  task automatic pressure_burst();
    if (cur_rs != RS_RUNNING) begin
      ensure_stopped();
      press();
      tick();
    end
    hold_starts++;
    repeat (40) begin
      if ($urandom_range(1) == 0) midi_rand();
      else tick();
    end
  endtask

  initial begin : stimulus
    logic [6:0] vel_plan [6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    snd_idle = 21;
    rcv_idle = 53;
    cur_rs = RS_RUNNING;
    items_sent = 0;
    vel_plan = '{7'd0, 7'd127, 7'($urandom_range(127)), 7'd1, 7'($urandom_range(127)),
                 7'd127};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // forward while running, then walk the preset pattern through its wrap
    send(mk_item(MODE_MIDI, 8'hff, 7'd127, 7'd127));
    send(mk_item(MODE_MIDI, 8'h00, 7'd0, 7'd0));
    repeat (4) tick();
    press();
    // stopped: note-off ignored, note-ons and ticks recorded
    send(mk_item(MODE_MIDI, MSG_NOTE_OFF, 7'd60, 7'd64));
    send(mk_item(MODE_MIDI, MSG_NOTE_ON | 8'h0f, 7'd127, 7'd0));
    tick();
    send(mk_item(MODE_MIDI, MSG_NOTE_ON, REST_NOTE, 7'd127));
    send(mk_item(MODE_MIDI, MSG_NOTE_ON | 8'h05, 7'd60, 7'd100));
    send(mk_item(MODE_UNUSED, 8'hff, 7'd127, 7'd127));
    press();
    send(mk_item(MODE_MIDI, 8'hb0, 7'd7, 7'd100));
    press();
    send(mk_item(MODE_MIDI, MSG_NOTE_ON | 8'h01, 7'd1, 7'd1));
    press();
    repeat (6) tick();
    press();

    items_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      snd_idle = (ph == 0) ? 21 : (ph == 1) ? 53 : 0;
      rcv_idle = (ph == 0) ? 53 : (ph == 1) ? 21 : 0;
      for (int half = 0; half < 2; half++) begin
        set_velocity(vel_plan[2 * ph + half]);
        if (half == 0) begin
          pressure_burst();
          well_formed(1'b1);
        end
        while (items_sent < RANDOM_ITEMS * (2 * ph + half + 1) / 6) begin
          if ($urandom_range(3) == 0) noise();
          else well_formed(1'b0);
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== midi_step_sequencer_unit.f =====
sv/msq_pkg.sv
sv/msq_ram.sv
sv/msq_front.sv
sv/msq_back.sv
sv/midi_step_sequencer_unit.sv
test/sequencer_checker.sv
test/testbench.sv
